// ===== hdl/dsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsp_pkg: shared types and codes for the shortest path tree block
// Opcodes, distance constants and the engine state encoding.
// ----------------------------------------------------------------------------
package dsp_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_RUN   = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  localparam logic [31:0] DIST_INF = 32'hFFFF_FFFF;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_INIT   = 10'b00_0000_0010,
    ST_SCAN   = 10'b00_0000_0100,
    ST_PICK   = 10'b00_0000_1000,
    ST_RLXHD  = 10'b00_0001_0000,
    ST_RLXE   = 10'b00_0010_0000,
    ST_RLXW   = 10'b00_0100_0000,
    ST_TREE   = 10'b00_1000_0000,
    ST_TREEHD = 10'b01_0000_0000,
    ST_OUT    = 10'b10_0000_0000
  } state_e;

endpackage : dsp_pkg
`default_nettype wire

// ===== hdl/dijkstra_shortest_path_tree.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dijkstra_shortest_path_tree: single-source shortest path tree engine
// Edge lists and node state sit in synchronous memories; one sequencer
// runs array Dijkstra and the parent claiming pass over them.
//
// Channel   Dir  Handshake            Payload
// cfg       in   cfg_valid/cfg_ready  cfg_data_i (node_count)
// in        in   in_valid/in_ready    opcode, node_a, node_b, edge_weight
// out       out  out_valid/out_ready  distance, parent, error, saturated
//
// Clear, load and read items are accepted in idle, which issues the memory
// read, then pass to the output step, which updates state and loads the
// result register. A run first initializes every node entry; each scan round
// reads one node entry per cycle, and each edge takes one read and one
// dependent node read-modify-write in both the relax and the tree pass.
// One item is in work at a time; a waiting result holds the next item in its
// output step. Until the first run, reads return unreachable with no parent.
// ----------------------------------------------------------------------------
module dijkstra_shortest_path_tree #(
  parameter int MaxNodes = 256,
  parameter int MaxEdges = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [8:0]  cfg_data_i,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [7:0]  node_a_i,
  input  wire logic [7:0]  node_b_i,
  input  wire logic [15:0] edge_weight_i,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      distance_o,
  output logic [7:0]       parent_node_o,
  output logic             parent_valid_o,
  output logic             error_o,
  output logic             saturated_o
);
  localparam int NW = $clog2(MaxNodes);
  localparam int EW = $clog2(MaxEdges);

  // node memory: {visited, claimed, has_parent, parent, distance}
  logic [31:0] dist_mem [MaxNodes];
  logic [7:0]  par_mem  [MaxNodes];
  logic [2:0]  flg_mem  [MaxNodes];  // visited, claimed, parent valid
  // edge memory
  logic [7:0]    tgt_mem  [MaxEdges];
  logic [15:0]   cost_mem [MaxEdges];
  logic [EW-1:0] link_mem [MaxEdges];
  logic [EW-1:0] head_mem [MaxNodes];
  logic [EW-1:0] tail_mem [MaxNodes];
  logic [MaxNodes-1:0] nonempty_q;

  dsp_pkg::state_e state_q;
  logic [8:0]  ncfg_q;
  logic [EW:0] nedges_q;
  logic        sat_q;
  logic        ran_q;
  logic [1:0]  op_q;
  logic [7:0]  a_q, b_q;
  logic [15:0] w_q;
  logic [NW:0] idx_q;
  logic [1:0]  sub_q;
  logic [31:0] bestd_q, du_q;
  logic [NW-1:0] best_q, u_q;
  logic        found_q;
  logic [EW-1:0] e_q, etail_q;
  logic [7:0]  et_q;
  logic [32:0] sum_q;
  logic        treepass_q;
  logic        outv_q;
  logic [31:0] od_q;
  logic [7:0]  op_par_q;
  logic        opv_q, oerr_q, osat_q;

  // registered read ports
  logic [31:0] rd_dist;
  logic [7:0]  rd_par;
  logic [2:0]  rd_flg;
  logic [7:0]  rd_tgt;
  logic [15:0] rd_cost;
  logic [EW-1:0] rd_link, rd_head, rd_tail;

  logic [NW-1:0] nrd_addr, nwr_addr;
  logic          nwr_en;
  logic [31:0]   nwr_dist;
  logic [7:0]    nwr_par;
  logic [2:0]    nwr_flg;
  logic [EW-1:0] erd_addr;

  logic [8:0] n_eff;
  always_comb begin
    n_eff = ncfg_q;
    if (ncfg_q == 9'd0) n_eff = 9'd1;
    if ({23'd0, n_eff} > MaxNodes) n_eff = 9'(MaxNodes);
  end

  assign cfg_ready = (state_q == dsp_pkg::ST_IDLE) && !outv_q;
  assign in_ready  = (state_q == dsp_pkg::ST_IDLE);
  assign out_valid = outv_q;
  assign distance_o = od_q;
  assign parent_node_o = op_par_q;
  assign parent_valid_o = opv_q;
  assign error_o = oerr_q;
  assign saturated_o = osat_q;

  wire a_bad = {1'b0, a_q} >= n_eff;
  wire b_bad = {1'b0, b_q} >= n_eff;
  wire et_ok = {1'b0, et_q} < n_eff;

  always_ff @(posedge clk_i) begin
    rd_dist <= dist_mem[nrd_addr];
    rd_par  <= par_mem[nrd_addr];
    rd_flg  <= flg_mem[nrd_addr];
    if (nwr_en) begin
      dist_mem[nwr_addr] <= nwr_dist;
      par_mem[nwr_addr]  <= nwr_par;
      flg_mem[nwr_addr]  <= nwr_flg;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_tgt  <= tgt_mem[erd_addr];
    rd_cost <= cost_mem[erd_addr];
    rd_link <= link_mem[erd_addr];
    rd_head <= head_mem[nrd_addr];
    rd_tail <= tail_mem[nrd_addr];
    if (state_q == dsp_pkg::ST_OUT && !outv_q && op_q == dsp_pkg::OP_LOAD && !a_bad && !b_bad
        && nedges_q < (EW+1)'(MaxEdges)) begin
      tgt_mem[nedges_q[EW-1:0]]  <= b_q;
      cost_mem[nedges_q[EW-1:0]] <= w_q;
      if (nonempty_q[a_q[NW-1:0]]) link_mem[rd_tail] <= nedges_q[EW-1:0];
      else head_mem[a_q[NW-1:0]] <= nedges_q[EW-1:0];
      tail_mem[a_q[NW-1:0]] <= nedges_q[EW-1:0];
    end
  end

  // combinational addressing and write data
  always_comb begin
    nrd_addr = a_q[NW-1:0];
    erd_addr = e_q;
    nwr_en   = 1'b0;
    nwr_addr = idx_q[NW-1:0];
    nwr_dist = dsp_pkg::DIST_INF;
    nwr_par  = rd_par;
    nwr_flg  = 3'b000;
    case (state_q)
      dsp_pkg::ST_IDLE: nrd_addr = node_a_i[NW-1:0];
      dsp_pkg::ST_INIT: begin
        nwr_en = 1'b1;
        if (idx_q[NW-1:0] == a_q[NW-1:0]) nwr_dist = 32'd0;
      end
      dsp_pkg::ST_SCAN: nrd_addr = idx_q[NW-1:0];
      dsp_pkg::ST_PICK: begin
        nrd_addr = best_q;
        nwr_addr = best_q;
        nwr_en = 1'b0;
      end
      dsp_pkg::ST_RLXHD: begin
        nrd_addr = u_q;
        if (sub_q == 2'd0) begin
          nwr_en = !treepass_q;
          nwr_addr = u_q;
          nwr_dist = rd_dist;
          nwr_flg = {1'b1, rd_flg[1:0]};
        end
      end
      dsp_pkg::ST_RLXE: nrd_addr = rd_tgt[NW-1:0];
      dsp_pkg::ST_RLXW: begin
        nrd_addr = et_q[NW-1:0];
        nwr_addr = et_q[NW-1:0];
        nwr_dist = rd_dist;
        nwr_par  = rd_par;
        nwr_flg  = rd_flg;
        if (!treepass_q) begin
          if (et_ok && !rd_flg[2] && sum_q[31:0] < rd_dist) begin
            nwr_en = 1'b1;
            nwr_dist = sum_q[31:0];
          end
        end else if (et_ok && !sum_q[32] && sum_q[31:0] != dsp_pkg::DIST_INF
                     && sum_q[31:0] == rd_dist && !rd_flg[1]) begin
          nwr_en = 1'b1;
          nwr_par = 8'(u_q);
          nwr_flg = {rd_flg[2], 2'b11};
        end
      end
      dsp_pkg::ST_TREE: nrd_addr = idx_q[NW-1:0];
      dsp_pkg::ST_TREEHD: nrd_addr = idx_q[NW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dsp_pkg::ST_IDLE;
      ncfg_q <= 9'd256;
      nedges_q <= '0;
      nonempty_q <= '0;
      sat_q <= 1'b0;
      ran_q <= 1'b0;
      outv_q <= 1'b0;
      treepass_q <= 1'b0;
      sub_q <= '0;
      idx_q <= '0;
    end else begin
      if (outv_q && out_ready) outv_q <= 1'b0;
      if (cfg_valid && cfg_ready) ncfg_q <= cfg_data_i;
      case (state_q)
        dsp_pkg::ST_IDLE: begin
          if (in_valid && in_ready) begin
            op_q <= opcode_i; a_q <= node_a_i; b_q <= node_b_i; w_q <= edge_weight_i;
            state_q <= dsp_pkg::ST_OUT;
            if (opcode_i == dsp_pkg::OP_RUN && {1'b0, node_a_i} < n_eff) begin
              state_q <= dsp_pkg::ST_INIT;
              idx_q <= '0;
              sat_q <= 1'b0;
              ran_q <= 1'b1;
            end
          end
        end
        dsp_pkg::ST_INIT: begin
          idx_q <= idx_q + 1'b1;
          if (idx_q == (NW+1)'(MaxNodes - 1)) begin
            state_q <= dsp_pkg::ST_SCAN;
            idx_q <= '0; sub_q <= '0; found_q <= 1'b0; bestd_q <= dsp_pkg::DIST_INF;
            treepass_q <= 1'b0;
          end
        end
        dsp_pkg::ST_SCAN: begin
          // sub 0: issue read of idx; from then on compare previous
          if (sub_q != 2'd0 && !rd_flg[2] && rd_dist < bestd_q) begin
            bestd_q <= rd_dist; best_q <= NW'(idx_q - 1'b1); found_q <= 1'b1;
          end
          sub_q <= 2'd1;
          if (sub_q != 2'd0 && idx_q == (NW+1)'(n_eff)) begin
            state_q <= dsp_pkg::ST_PICK;
          end else if (idx_q != (NW+1)'(n_eff)) begin
            idx_q <= idx_q + 1'b1;
          end
        end
        dsp_pkg::ST_PICK: begin
          if (!found_q) begin
            state_q <= dsp_pkg::ST_TREE; treepass_q <= 1'b1; idx_q <= '0; sub_q <= '0;
          end else begin
            u_q <= best_q; du_q <= bestd_q; sub_q <= '0;
            state_q <= dsp_pkg::ST_RLXHD;
          end
        end
        dsp_pkg::ST_RLXHD: begin
          // sub 0 marks visited (rd holds best entry), sub 1 waits head/tail
          sub_q <= sub_q + 1'b1;
          if (sub_q == 2'd1) begin
            sub_q <= '0;
            if (!nonempty_q[u_q]) begin
              state_q <= treepass_q ? dsp_pkg::ST_TREE : dsp_pkg::ST_SCAN;
              idx_q <= treepass_q ? idx_q + 1'b1 : '0;
              found_q <= 1'b0; bestd_q <= dsp_pkg::DIST_INF;
            end else begin
              e_q <= rd_head; etail_q <= rd_tail;
              state_q <= dsp_pkg::ST_RLXE;
            end
          end
        end
        dsp_pkg::ST_RLXE: begin
          // sub 0: edge read issued; sub 1: edge data, node read issued
          if (sub_q == 2'd0) sub_q <= 2'd1;
          else begin
            sub_q <= '0;
            et_q <= rd_tgt;
            sum_q <= {1'b0, du_q} + {17'd0, rd_cost};
            if ({1'b0, du_q} + {17'd0, rd_cost} >= {1'b0, dsp_pkg::DIST_INF}) begin
              sum_q <= {1'b1, dsp_pkg::DIST_INF};
            end
            e_q <= rd_link;
            state_q <= dsp_pkg::ST_RLXW;
            if (e_q == etail_q) sub_q <= 2'd2;
          end
        end
        dsp_pkg::ST_RLXW: begin
          if (!treepass_q && et_ok && !rd_flg[2] && sum_q[32]) sat_q <= 1'b1;
          sub_q <= '0;
          if (sub_q == 2'd2) begin
            state_q <= treepass_q ? dsp_pkg::ST_TREE : dsp_pkg::ST_SCAN;
            idx_q <= treepass_q ? idx_q + 1'b1 : '0;
            found_q <= 1'b0; bestd_q <= dsp_pkg::DIST_INF;
          end else state_q <= dsp_pkg::ST_RLXE;
        end
        dsp_pkg::ST_TREE: begin
          if (idx_q == (NW+1)'(n_eff)) state_q <= dsp_pkg::ST_OUT;
          else state_q <= dsp_pkg::ST_TREEHD;
        end
        dsp_pkg::ST_TREEHD: begin
          if (rd_dist == dsp_pkg::DIST_INF) idx_q <= idx_q + 1'b1;
          else begin
            u_q <= idx_q[NW-1:0]; du_q <= rd_dist; sub_q <= 2'd1;
            state_q <= dsp_pkg::ST_RLXHD;
          end
          if (rd_dist == dsp_pkg::DIST_INF) state_q <= dsp_pkg::ST_TREE;
        end
        dsp_pkg::ST_OUT: begin
          if (!outv_q) begin
            outv_q <= 1'b1;
            od_q <= '0; op_par_q <= '0; opv_q <= 1'b0; oerr_q <= 1'b0; osat_q <= sat_q;
            state_q <= dsp_pkg::ST_IDLE;
            case (op_q)
              dsp_pkg::OP_CLEAR: begin
                nonempty_q <= '0; nedges_q <= '0; osat_q <= 1'b0;
              end
              dsp_pkg::OP_LOAD: begin
                osat_q <= 1'b0;
                if (a_bad || b_bad || nedges_q >= (EW+1)'(MaxEdges)) oerr_q <= 1'b1;
                else begin
                  nedges_q <= nedges_q + 1'b1;
                  nonempty_q[a_q[NW-1:0]] <= 1'b1;
                end
              end
              dsp_pkg::OP_RUN: oerr_q <= a_bad;
              dsp_pkg::OP_READ: begin
                if (a_bad) oerr_q <= 1'b1;
                else if (!ran_q) od_q <= dsp_pkg::DIST_INF;
                else begin
                  od_q <= rd_dist; opv_q <= rd_flg[0];
                  if (rd_flg[0]) op_par_q <= rd_par;
                end
              end
              default: ;
            endcase
          end
        end
        default: state_q <= dsp_pkg::ST_IDLE;
      endcase
    end
  end

  a_one_hot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != dsp_pkg::ST_IDLE) |-> !in_ready) else $error("accepted while busy");
  a_edges_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nedges_q <= (EW+1)'(MaxEdges)) else $error("edge count overflow");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");

endmodule : dijkstra_shortest_path_tree
`default_nettype wire
